### hw/rtl/lfubf_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the lfu batch flush cache
package lfubf_pkg;

  localparam int KEY_W      = 64;
  localparam int KLEN_W     = 4;
  localparam int VAL_W      = 64;
  localparam int VLEN_W     = 16;
  localparam int OCC_W      = 5;
  localparam int CAP_W      = 5;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int KEY_BYTES  = 8;

  localparam logic [PCT_W-1:0] PCT_DEFAULT = 7'd20;
  localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;

  // floor(x / 100) for x below 43690
  localparam int RECIP     = 5243;
  localparam int RECIP_SH  = 19;
  localparam int PROD_W    = CAP_W + PCT_W;
  localparam int RPROD_W   = PROD_W + 13;

  typedef enum logic [1:0] {
    REQ_SET = 2'd0,
    REQ_ADD = 2'd1,
    REQ_GET = 2'd2,
    REQ_DEL = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_HIT     = 2'd1,
    ST_MISS    = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 2'd0,
    CFG_FLUSH    = 2'd1,
    CFG_RSVD2    = 2'd2,
    CFG_RSVD3    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [KLEN_W-1:0] klen;
    logic [VAL_W-1:0]  value;
    logic [VLEN_W-1:0] vlen;
  } lfubf_entry_t;

  function automatic logic [KEY_W-1:0] key_mask(input logic [KLEN_W-1:0] klen);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (KLEN_W'(b) < klen) m[b*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

### hw/rtl/lfubf_if.sv
`timescale 1ns / 1ps
// channel interfaces of the lfu batch flush cache
interface lfubf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] key;
  logic [3:0]  key_length;
  logic [63:0] value;
  logic [15:0] value_length;
  modport source(output valid, req_type, key, key_length, value, value_length, input ready);
  modport sink(input valid, req_type, key, key_length, value, value_length, output ready);
endinterface

interface lfubf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] value_out;
  logic [15:0] value_length_out;
  logic [4:0]  occupancy;
  modport source(output valid, status, value_out, value_length_out, occupancy, input ready);
  modport sink(input valid, status, value_out, value_length_out, occupancy, output ready);
endinterface

interface lfubf_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/lfubf_flush_calc.sv
`timescale 1ns / 1ps
// eviction count and full check from capacity, eviction percentage and occupancy
module lfubf_flush_calc #(
  parameter int ENTRIES = 16
) (
  input  logic [lfubf_pkg::CAP_W-1:0]      capacity,
  input  logic [lfubf_pkg::PCT_W-1:0]      evict_pct,
  input  logic [$clog2(ENTRIES+1)-1:0]     count,
  output logic                             full,
  output logic [$clog2(ENTRIES+1)-1:0]     n
);
  import lfubf_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int NW = ((CW > CAP_W) ? CW : CAP_W) + 1;

  logic [CAP_W-1:0]   cap_c;
  logic [PCT_W-1:0]   pct_c;
  logic [PROD_W-1:0]  prod;
  logic [RPROD_W-1:0] rprod;
  logic [CAP_W-1:0]   q;
  logic [CAP_W-1:0]   n1;
  logic [NW-1:0]      count_x;
  logic [NW-1:0]      cap_x;
  logic [NW-1:0]      extra;
  logic [NW-1:0]      nsum;

  always_comb begin
    if (capacity == '0) cap_c = CAP_W'(1);
    else if (9'(capacity) > 9'(ENTRIES)) cap_c = CAP_W'(ENTRIES);
    else cap_c = capacity;
    if (evict_pct == '0 || evict_pct > PCT_FULL) pct_c = PCT_DEFAULT;
    else pct_c = evict_pct;
    prod    = PROD_W'(cap_c) * PROD_W'(pct_c);
    rprod   = RPROD_W'(prod) * RPROD_W'(RECIP);
    q       = CAP_W'(rprod >> RECIP_SH);
    n1      = (q == '0) ? CAP_W'(1) : q;
    count_x = NW'(count);
    cap_x   = NW'(cap_c);
    extra   = (count_x > cap_x) ? (count_x - cap_x) : '0;
    nsum    = NW'(n1) + extra;
    n       = (nsum > count_x) ? count : CW'(nsum);
    full    = (count_x >= cap_x);
  end

endmodule

### hw/rtl/lfu_batch_flush_cache.sv
`timescale 1ns / 1ps
// lfu batch flush cache: key/value table in synchronous memories with lfu batch eviction
// lookup scans the slots in order until the key matches or the last slot is read; a new
// key then searches for a free slot; at capacity it first evicts the n least used entries
// and subtracts the lowest remaining use count from all that stay; one item is in flight at a time
// synchronous active-low reset clears valid bits, occupancy and config (capacity 16, percent 20)
module lfu_batch_flush_cache #(
  parameter int ENTRIES    = 16,
  parameter int USAGE_BITS = 32
) (
  input logic         clk,
  input logic         rst_n,
  lfubf_in_if.sink    in_if,
  lfubf_out_if.source out_if,
  lfubf_cfg_if.sink   cfg_if
);
  import lfubf_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int UW = USAGE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_ACT, S_EV_SCAN, S_EV_CLEAR, S_EV_FLOOR, S_EV_SUB, S_FREE, S_RESP
  } state_t;

  state_t             state_r;
  logic [CAP_W-1:0]   cap_r;
  logic [PCT_W-1:0]   pct_r;
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] gone_r;
  logic [CW-1:0]      count_r;
  logic [IW-1:0]      idx_r;
  logic               phase_r;
  req_t               req_r;
  logic [KEY_W-1:0]   key_r;
  logic [KLEN_W-1:0]  klen_r;
  logic [VAL_W-1:0]   val_r;
  logic [VLEN_W-1:0]  vlen_r;
  logic               hit_r;
  logic [IW-1:0]      hit_idx_r;
  logic [VAL_W-1:0]   hit_val_r;
  logic [VLEN_W-1:0]  hit_vlen_r;
  logic [UW-1:0]      hit_use_r;
  logic               pick_ok_r;
  logic [IW-1:0]      pick_idx_r;
  logic [UW-1:0]      pick_use_r;
  logic [CW-1:0]      done_r;
  logic [CW-1:0]      n_r;
  logic [UW-1:0]      floor_r;
  logic               any_r;
  status_t            status_r;
  logic [VAL_W-1:0]   vout_r;
  logic [VLEN_W-1:0]  vlout_r;

  lfubf_entry_t       dmem [ENTRIES];
  logic [UW-1:0]      umem [ENTRIES];
  lfubf_entry_t       dq_r;
  logic [UW-1:0]      uq_r;

  logic               d_we;
  logic [IW-1:0]      d_addr;
  lfubf_entry_t       d_wdata;
  logic               u_we;
  logic [IW-1:0]      u_addr;
  logic [UW-1:0]      u_wdata;

  logic               ev_full;
  logic [CW-1:0]      ev_n;
  logic               last;
  logic               match;
  logic               cand;
  logic [IW-1:0]      sel_idx;
  logic [KLEN_W-1:0]  in_klen;
  logic               in_klen_ok;

  lfubf_flush_calc #(.ENTRIES(ENTRIES)) u_flush (
    .capacity (cap_r),
    .evict_pct(pct_r),
    .count    (count_r),
    .full     (ev_full),
    .n        (ev_n)
  );

  assign in_klen    = in_if.key_length;
  assign in_klen_ok = (in_klen != '0) && (in_klen <= KLEN_W'(KEY_BYTES));
  assign last       = (idx_r == IW'(ENTRIES - 1));
  assign match      = valid_r[idx_r] && (dq_r.key == key_r) && (dq_r.klen == klen_r);
  assign cand       = valid_r[idx_r] && !gone_r[idx_r] && (!pick_ok_r || uq_r < pick_use_r);
  assign sel_idx    = cand ? idx_r : pick_idx_r;

  assign in_if.ready             = (state_r == S_IDLE);
  assign cfg_if.ready            = 1'b1;
  assign out_if.valid            = (state_r == S_RESP);
  assign out_if.status           = status_r;
  assign out_if.value_out        = vout_r;
  assign out_if.value_length_out = vlout_r;
  assign out_if.occupancy        = OCC_W'(count_r);

  // memory write ports
  always_comb begin
    d_we    = 1'b0;
    d_addr  = idx_r;
    d_wdata = '{key: key_r, klen: klen_r, value: val_r, vlen: vlen_r};
    u_we    = 1'b0;
    u_addr  = idx_r;
    u_wdata = '0;
    unique case (state_r)
      S_ACT: begin
        if (req_r == REQ_SET && vlen_r != '0 && hit_r) begin
          d_we   = 1'b1;
          d_addr = hit_idx_r;
          u_we   = 1'b1;
          u_addr = hit_idx_r;
        end else if (req_r == REQ_GET && hit_r) begin
          u_we    = 1'b1;
          u_addr  = hit_idx_r;
          u_wdata = (&hit_use_r) ? hit_use_r : hit_use_r + UW'(1);
        end
      end
      S_EV_SUB: begin
        if (phase_r && valid_r[idx_r]) begin
          u_we    = 1'b1;
          u_wdata = uq_r - floor_r;
        end
      end
      S_FREE: begin
        if (!valid_r[idx_r]) begin
          d_we = 1'b1;
          u_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (d_we) dmem[d_addr] <= d_wdata;
    if (u_we) umem[u_addr] <= u_wdata;
    dq_r <= dmem[idx_r];
    uq_r <= umem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_W'(16);
      pct_r   <= PCT_DEFAULT;
    end else if (cfg_if.valid) begin
      if (cfg_if.index == CFG_CAPACITY) cap_r <= cfg_if.data[CAP_W-1:0];
      else if (cfg_if.index == CFG_FLUSH) pct_r <= cfg_if.data[PCT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      count_r <= '0;
      idx_r   <= '0;
      phase_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            req_r   <= req_t'(in_if.req_type);
            key_r   <= in_if.key & key_mask(in_klen);
            klen_r  <= in_klen;
            val_r   <= in_if.value;
            vlen_r  <= in_if.value_length;
            hit_r   <= 1'b0;
            idx_r   <= '0;
            phase_r <= 1'b0;
            vout_r  <= '0;
            vlout_r <= '0;
            if (in_klen_ok) begin
              state_r <= S_LOOK;
            end else begin
              status_r <= ST_MISS;
              state_r  <= S_RESP;
            end
          end
        end
        S_LOOK: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else if (match) begin
            hit_r      <= 1'b1;
            hit_idx_r  <= idx_r;
            hit_val_r  <= dq_r.value;
            hit_vlen_r <= dq_r.vlen;
            hit_use_r  <= uq_r;
            state_r    <= S_ACT;
          end else if (last) begin
            state_r <= S_ACT;
          end else begin
            idx_r   <= idx_r + IW'(1);
            phase_r <= 1'b0;
          end
        end
        S_ACT: begin
          state_r  <= S_RESP;
          status_r <= ST_MISS;
          unique case (req_r)
            REQ_SET, REQ_ADD: begin
              if (vlen_r == '0) begin
                status_r <= ST_MISS;
              end else if (hit_r && req_r == REQ_ADD) begin
                status_r <= ST_PRESENT;
              end else if (hit_r) begin
                status_r <= ST_DONE;
              end else begin
                status_r  <= ST_DONE;
                idx_r     <= '0;
                phase_r   <= 1'b0;
                gone_r    <= '0;
                done_r    <= '0;
                pick_ok_r <= 1'b0;
                n_r       <= ev_n;
                state_r   <= ev_full ? S_EV_SCAN : S_FREE;
              end
            end
            REQ_GET: begin
              if (hit_r) begin
                status_r <= ST_HIT;
                vout_r   <= hit_val_r;
                vlout_r  <= hit_vlen_r;
              end
            end
            REQ_DEL: begin
              if (hit_r) begin
                status_r           <= ST_DONE;
                valid_r[hit_idx_r] <= 1'b0;
                count_r            <= count_r - CW'(1);
              end
            end
            default: ;
          endcase
        end
        S_EV_SCAN: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else begin
            phase_r <= 1'b0;
            if (cand) begin
              pick_ok_r  <= 1'b1;
              pick_idx_r <= idx_r;
              pick_use_r <= uq_r;
            end
            if (last) begin
              gone_r[sel_idx] <= 1'b1;
              done_r          <= done_r + CW'(1);
              idx_r           <= '0;
              pick_ok_r       <= 1'b0;
              if (done_r + CW'(1) == n_r) state_r <= S_EV_CLEAR;
            end else begin
              idx_r <= idx_r + IW'(1);
            end
          end
        end
        S_EV_CLEAR: begin
          valid_r <= valid_r & ~gone_r;
          count_r <= count_r - n_r;
          idx_r   <= '0;
          phase_r <= 1'b0;
          any_r   <= 1'b0;
          floor_r <= '0;
          state_r <= S_EV_FLOOR;
        end
        S_EV_FLOOR: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else begin
            phase_r <= 1'b0;
            if (valid_r[idx_r] && (!any_r || uq_r < floor_r)) begin
              floor_r <= uq_r;
              any_r   <= 1'b1;
            end
            if (last) begin
              idx_r   <= '0;
              state_r <= S_EV_SUB;
            end else begin
              idx_r <= idx_r + IW'(1);
            end
          end
        end
        S_EV_SUB: begin
          if (!phase_r) begin
            phase_r <= 1'b1;
          end else begin
            phase_r <= 1'b0;
            idx_r   <= last ? '0 : idx_r + IW'(1);
            if (last) state_r <= S_FREE;
          end
        end
        S_FREE: begin
          if (!valid_r[idx_r]) begin
            valid_r[idx_r] <= 1'b1;
            count_r        <= count_r + CW'(1);
            state_r        <= S_RESP;
          end else if (last) begin
            state_r <= S_RESP;
          end else begin
            idx_r <= idx_r + IW'(1);
          end
        end
        S_RESP: begin
          if (out_if.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(ENTRIES)) else $error("occupancy above table size");

  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == 32'(count_r)) else $error("occupancy differs from valid bits");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_if.ready && out_if.valid)) else $error("input open while result pending");

  a_evict_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV_SCAN) |-> (n_r != '0 && done_r < n_r)) else $error("bad eviction count");

endmodule
